// ===== rtl/lz4bd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd_pkg
// Shared types and constants of the LZ4 block decoder.
// ----------------------------------------------------------------------------
package lz4bd_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam logic [23:0] LEN_MAX   = 24'hFF_FFFF;
    localparam logic [3:0]  LIT_EXT_CODE   = 4'd15;
    localparam logic [23:0] MATCH_EXT_CODE = 24'd19;
    localparam logic [7:0]  EXT_BYTE  = 8'd255;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OFF   = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_LEN_OVF   = 3'd3;
    localparam logic [2:0] ST_BUSY_IN   = 3'd4;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // classified item handed from the parser to the back end
    typedef struct packed {
        logic       is_match;
        logic       has_byte;
        logic [7:0] lit_byte;
        logic       last_byte;
        logic       match_pending;
        logic       block_done;
        logic [2:0] status;
    } item_t;

endpackage

// ===== rtl/lz4bd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd channels
// Valid/ready channels for compressed input items and decoded result items.
// ----------------------------------------------------------------------------
interface lz4bd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface lz4bd_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       match_pending;
    logic       block_done;
    logic [2:0] status;

    modport source (output valid, output has_byte, output out_byte, output last_byte,
                    output match_pending, output block_done, output status,
                    input ready);
    modport sink   (input valid, input has_byte, input out_byte, input last_byte,
                    input match_pending, input block_done, input status,
                    output ready);
endinterface

// ===== rtl/lz4bd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lz4bd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd_front
// Stream parser: header, tokens, lengths, offsets and counters.
// ----------------------------------------------------------------------------
module lz4bd_front #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc,
    input  logic                            cmd,
    input  logic [7:0]                      in_byte,
    output lz4bd_pkg::item_t                item,
    output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
    output logic [$clog2(WINDOW_BYTES)-1:0] wr_addr
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [31:0] WIN32 = 32'(WINDOW_BYTES);

    typedef enum logic [2:0] {
        PH_HEADER, PH_TOKEN, PH_LIT_EXT, PH_LITERAL,
        PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_MATCH
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hc_reg, hc_next;
    logic [31:0] exp_out_reg, exp_out_next;
    logic [31:0] exp_in_reg, exp_in_next;
    logic [31:0] in_cnt_reg, in_cnt_next;
    logic [31:0] out_cnt_reg, out_cnt_next;
    logic [23:0] lit_reg, lit_next;
    logic [23:0] ml_reg, ml_next;
    logic [15:0] off_reg, off_next;
    logic [AW-1:0] wp_reg, wp_next;

    logic [2:0]  st;
    logic        has, last, is_match;
    logic [31:0] rp32, off32, wp32;
    logic [24:0] lsum;
    logic [15:0] off_new;

    always_comb
    begin
        phase_next   = phase_reg;
        hc_next      = hc_reg;
        exp_out_next = exp_out_reg;
        exp_in_next  = exp_in_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        lit_next     = lit_reg;
        ml_next      = ml_reg;
        off_next     = off_reg;
        wp_next      = wp_reg;
        st           = lz4bd_pkg::ST_OK;
        has          = 1'b0;
        last         = 1'b0;
        is_match     = 1'b0;
        lsum         = '0;
        off_new      = off_reg;

        wp32  = 32'(wp_reg);
        off32 = 32'(off_reg);
        rp32  = (wp32 >= off32) ? (wp32 - off32) : (wp32 + WIN32 - off32);

        if (cmd == lz4bd_pkg::CMD_DRAIN)
        begin
            if (phase_reg == PH_MATCH)
            begin
                is_match = 1'b1;
                if (out_cnt_reg >= exp_out_reg)
                begin
                    st = lz4bd_pkg::ST_OVERRUN;
                end
                else
                begin
                    has          = 1'b1;
                    out_cnt_next = out_cnt_reg + 32'd1;
                    last         = (out_cnt_next == exp_out_reg);
                    wp_next      = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + 1'b1;
                end
                if (ml_reg != '0)
                begin
                    ml_next = ml_reg - 24'd1;
                end
                if (ml_next == '0)
                begin
                    phase_next = PH_TOKEN;
                end
            end
        end
        else if (phase_reg == PH_MATCH)
        begin
            st = lz4bd_pkg::ST_BUSY_IN;
        end
        else
        begin
            if (phase_reg != PH_HEADER && in_cnt_reg != 32'hFFFF_FFFF)
            begin
                in_cnt_next = in_cnt_reg + 32'd1;
            end
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hc_reg == 4'd0)
                    begin
                        exp_out_next = '0;
                        exp_in_next  = '0;
                    end
                    if (hc_reg[3:2] == 2'b01)
                    begin
                        exp_out_next[8*hc_reg[1:0] +: 8] = exp_out_next[8*hc_reg[1:0] +: 8]
                                                           | in_byte;
                    end
                    else if (hc_reg[3:2] == 2'b10)
                    begin
                        exp_in_next[8*hc_reg[1:0] +: 8] = exp_in_next[8*hc_reg[1:0] +: 8]
                                                          | in_byte;
                    end
                    if (hc_reg == 4'(lz4bd_pkg::HDR_BYTES - 1))
                    begin
                        hc_next      = '0;
                        in_cnt_next  = '0;
                        out_cnt_next = '0;
                        lit_next     = '0;
                        ml_next      = '0;
                        off_next     = '0;
                        wp_next      = '0;
                        phase_next   = PH_TOKEN;
                    end
                    else
                    begin
                        hc_next = hc_reg + 4'd1;
                    end
                end
                PH_TOKEN:
                begin
                    lit_next = 24'(in_byte[7:4]);
                    ml_next  = 24'(in_byte[3:0]) + 24'd4;
                    if (in_byte[7:4] == lz4bd_pkg::LIT_EXT_CODE)
                    begin
                        phase_next = PH_LIT_EXT;
                    end
                    else if (in_byte[7:4] != 4'd0)
                    begin
                        phase_next = PH_LITERAL;
                    end
                    else if (in_cnt_next >= exp_in_reg)
                    begin
                        phase_next = PH_HEADER;
                        hc_next    = '0;
                        lit_next   = '0;
                        ml_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_OFF_LO;
                    end
                end
                PH_LIT_EXT:
                begin
                    lsum = {1'b0, lit_reg} + 25'(in_byte);
                    if (lsum[24])
                    begin
                        st       = lz4bd_pkg::ST_LEN_OVF;
                        lit_next = lz4bd_pkg::LEN_MAX;
                    end
                    else
                    begin
                        lit_next = lsum[23:0];
                    end
                    if (in_byte != lz4bd_pkg::EXT_BYTE)
                    begin
                        phase_next = PH_LITERAL;
                    end
                end
                PH_LITERAL:
                begin
                    if (out_cnt_reg >= exp_out_reg)
                    begin
                        st = lz4bd_pkg::ST_OVERRUN;
                    end
                    else
                    begin
                        has          = 1'b1;
                        out_cnt_next = out_cnt_reg + 32'd1;
                        last         = (out_cnt_next == exp_out_reg);
                        wp_next      = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + 1'b1;
                    end
                    if (lit_reg != '0)
                    begin
                        lit_next = lit_reg - 24'd1;
                    end
                    if (lit_next == '0)
                    begin
                        if (in_cnt_next >= exp_in_reg)
                        begin
                            phase_next = PH_HEADER;
                            hc_next    = '0;
                            lit_next   = '0;
                            ml_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_OFF_LO;
                        end
                    end
                end
                PH_OFF_LO:
                begin
                    off_next   = {8'd0, in_byte};
                    phase_next = PH_OFF_HI;
                end
                PH_OFF_HI, PH_MATCH_EXT:
                begin
                    if (phase_reg == PH_OFF_HI)
                    begin
                        off_new  = {in_byte, off_reg[7:0]};
                        off_next = off_new;
                    end
                    else
                    begin
                        lsum = {1'b0, ml_reg} + 25'(in_byte);
                        if (lsum[24])
                        begin
                            st      = lz4bd_pkg::ST_LEN_OVF;
                            ml_next = lz4bd_pkg::LEN_MAX;
                        end
                        else
                        begin
                            ml_next = lsum[23:0];
                        end
                    end
                    if (phase_reg == PH_OFF_HI && ml_reg == lz4bd_pkg::MATCH_EXT_CODE)
                    begin
                        phase_next = PH_MATCH_EXT;
                    end
                    else if (phase_reg == PH_MATCH_EXT && in_byte == lz4bd_pkg::EXT_BYTE)
                    begin
                        phase_next = PH_MATCH_EXT;
                    end
                    // offset check once the match length is final
                    else if (off_new == '0 || 32'(off_new) > out_cnt_reg
                             || 32'(off_new) > WIN32)
                    begin
                        if (st == lz4bd_pkg::ST_OK)
                        begin
                            st = lz4bd_pkg::ST_BAD_OFF;
                        end
                        ml_next    = '0;
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        phase_next = PH_MATCH;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        item.is_match      = is_match;
        item.has_byte      = has;
        item.lit_byte      = is_match ? 8'd0 : (has ? in_byte : 8'd0);
        item.last_byte     = last;
        item.match_pending = (phase_next == PH_MATCH);
        item.block_done    = (phase_next == PH_HEADER) && (hc_next == 4'd0);
        item.status        = st;
        rd_addr            = rp32[AW-1:0];
        wr_addr            = wp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hc_reg      <= '0;
            exp_out_reg <= '0;
            exp_in_reg  <= '0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            lit_reg     <= '0;
            ml_reg      <= '0;
            off_reg     <= '0;
            wp_reg      <= '0;
        end
        else if (acc)
        begin
            phase_reg   <= phase_next;
            hc_reg      <= hc_next;
            exp_out_reg <= exp_out_next;
            exp_in_reg  <= exp_in_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            lit_reg     <= lit_next;
            ml_reg      <= ml_next;
            off_reg     <= off_next;
            wp_reg      <= wp_next;
        end
    end

endmodule

// ===== rtl/lz4bd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd_back
// Item queue stage, history store with write forwarding, output register.
// ----------------------------------------------------------------------------
module lz4bd_back #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc,
    output logic                            take,
    input  lz4bd_pkg::item_t                item,
    input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
    input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
    lz4bd_out_if.source                     decompressed
);

    localparam int AW = $clog2(WINDOW_BYTES);

    logic             p_valid_reg;
    lz4bd_pkg::item_t p_item_reg;
    logic [AW-1:0]    p_waddr_reg;
    logic             p_fwd_reg;

    logic             o_valid_reg;
    lz4bd_pkg::item_t o_item_reg;
    logic [7:0]       o_byte_reg;

    logic             p_adv;
    logic [7:0]       ram_q;
    logic [7:0]       byte_val;
    logic             fwd;

    assign p_adv = p_valid_reg && (!o_valid_reg || decompressed.ready);
    assign take  = !p_valid_reg || p_adv;

    // the write of the item ahead lands on the same edge as this read
    assign fwd = p_valid_reg && p_item_reg.has_byte && (p_waddr_reg == rd_addr);

    always_comb
    begin
        if (!p_item_reg.has_byte)
        begin
            byte_val = 8'd0;
        end
        else if (!p_item_reg.is_match)
        begin
            byte_val = p_item_reg.lit_byte;
        end
        else if (p_fwd_reg)
        begin
            byte_val = o_byte_reg;
        end
        else
        begin
            byte_val = ram_q;
        end
    end

    lz4bd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .clk   (clk),
        .we    (p_adv && p_item_reg.has_byte),
        .waddr (p_waddr_reg),
        .wdata (byte_val),
        .re    (acc),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                p_valid_reg <= acc;
            end
            if (p_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (decompressed.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_item_reg  <= item;
            p_waddr_reg <= wr_addr;
            p_fwd_reg   <= fwd;
        end
        if (p_adv)
        begin
            o_item_reg <= p_item_reg;
            o_byte_reg <= byte_val;
        end
    end

    assign decompressed.valid         = o_valid_reg;
    assign decompressed.has_byte      = o_item_reg.has_byte;
    assign decompressed.out_byte      = o_byte_reg;
    assign decompressed.last_byte     = o_item_reg.last_byte;
    assign decompressed.match_pending = o_item_reg.match_pending;
    assign decompressed.block_done    = o_item_reg.block_done;
    assign decompressed.status        = o_item_reg.status;

endmodule

// ===== rtl/lz4_block_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4_block_decoder_unit
// LZ4 block decoder: one compressed byte or one match drain per item.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is not stalled and returns
// one result item per item via the queue stage and output register. The parser
// updates all stream state in the cycle an item is accepted; the history store
// is a WINDOW_BYTES x 8 RAM with one write and one registered read port, and a
// byte written by the directly preceding item is forwarded around it,
// so a drain can follow any item in the next cycle. Send drain items while
// match_pending is high; a compressed byte sent then is dropped with status 4.
module lz4_block_decoder_unit #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    lz4bd_in_if.sink    compressed,
    lz4bd_out_if.source decompressed
);

    localparam int AW = $clog2(WINDOW_BYTES);

    logic             acc;
    logic             take;
    lz4bd_pkg::item_t item;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    assign compressed.ready = take;
    assign acc = compressed.valid && take;

    lz4bd_front #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .cmd     (compressed.cmd),
        .in_byte (compressed.in_byte),
        .item    (item),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr)
    );

    lz4bd_back #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .take         (take),
        .item         (item),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .decompressed (decompressed)
    );

endmodule

// ===== tb/lz4bd_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4bd testbench channels
// The valid/ready channel interfaces are defined with the design and reused
// by the testbench, so this file holds no extra interface, only a package.
// ----------------------------------------------------------------------------
package lz4bd_tb_pkg;

    // the depth of the history window modelled by the predictor
    localparam int unsigned TB_WINDOW = 65536;

endpackage

// ===== tb/lz4_block_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4_block_decoder_unit_tb
// Self-checking bench for the LZ4 block decoder. Well-formed blocks with random
// content, plus malformed and noisy items, are sent with random idling; a
// behavioral decoder predicts every result item, which is checked field by field.
// ----------------------------------------------------------------------------
module lz4_block_decoder_unit_tb;

    localparam int WIN      = lz4bd_tb_pkg::TB_WINDOW;
    localparam int WD_LIMIT = 20000;
    localparam int HOLD_LEN = 200;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
    } req_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       last_byte;
        logic       match_pending;
        logic       block_done;
        logic [2:0] status;
    } res_t;

    typedef enum logic [2:0] {
        PH_HEADER, PH_TOKEN, PH_LIT_EXT, PH_LITERAL,
        PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_MATCH
    } phase_t;

    logic clk;
    logic rst_n;

    lz4bd_in_if  compressed ();
    lz4bd_out_if decompressed ();

    lz4_block_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .compressed  (compressed),
        .decompressed(decompressed)
    );

    // predictor state
    phase_t      dec_phase;
    logic [3:0]  dec_hdr_cnt;
    logic [31:0] dec_out_size;
    logic [31:0] dec_in_size;
    logic [31:0] dec_in_cnt;
    logic [31:0] dec_out_cnt;
    logic [23:0] dec_lit_left;
    logic [23:0] dec_match_left;
    logic [15:0] dec_offset;
    logic [7:0]  dec_hist [0:WIN-1];
    res_t        cur;

    req_t pending_items[$];
    res_t expected_results[$];

    int  errors;
    bit  gen_done;
    bit  sender_hold;
    bit  quiet_tail;
    int  sink_hold_cycles;
    int  hold_requests;
    int  holds_served;
    int  idle_cycles;
    int  pushed_items;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void flag(logic [2:0] s);
        if (cur.status == lz4bd_pkg::ST_OK)
            cur.status = s;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        if (dec_out_cnt >= dec_out_size)
        begin
            flag(lz4bd_pkg::ST_OVERRUN);
            return;
        end
        dec_hist[dec_out_cnt[15:0]] = b;
        dec_out_cnt   = dec_out_cnt + 32'd1;
        cur.has_byte  = 1'b1;
        cur.out_byte  = b;
        cur.last_byte = (dec_out_cnt == dec_out_size);
    endfunction

    function automatic logic [23:0] grow_len(logic [23:0] len, logic [7:0] b);
        logic [24:0] s;
        s = {1'b0, len} + 25'(b);
        if (s[24])
        begin
            flag(lz4bd_pkg::ST_LEN_OVF);
            return lz4bd_pkg::LEN_MAX;
        end
        return s[23:0];
    endfunction

    function automatic void close_literals();
        if (dec_in_cnt >= dec_in_size)
        begin
            dec_phase      = PH_HEADER;
            dec_hdr_cnt    = '0;
            dec_lit_left   = '0;
            dec_match_left = '0;
        end
        else
        begin
            dec_phase = PH_OFF_LO;
        end
    endfunction

    function automatic void open_match();
        if (dec_offset == '0 || 32'(dec_offset) > dec_out_cnt)
        begin
            flag(lz4bd_pkg::ST_BAD_OFF);
            dec_match_left = '0;
            dec_phase      = PH_TOKEN;
        end
        else
        begin
            dec_phase = PH_MATCH;
        end
    endfunction

    function automatic void predict_decode(req_t it);
        logic [7:0]  b;
        logic [15:0] rp;
        b   = it.in_byte;
        cur = '0;
        if (it.cmd == lz4bd_pkg::CMD_DRAIN)
        begin
            if (dec_phase == PH_MATCH)
            begin
                rp = dec_out_cnt[15:0] - dec_offset;
                put_byte(dec_hist[rp]);
                if (dec_match_left > 0)
                    dec_match_left = dec_match_left - 24'd1;
                if (dec_match_left == 0)
                    dec_phase = PH_TOKEN;
            end
        end
        else if (dec_phase == PH_MATCH)
        begin
            flag(lz4bd_pkg::ST_BUSY_IN);
        end
        else
        begin
            if (dec_phase != PH_HEADER && dec_in_cnt != 32'hFFFF_FFFF)
                dec_in_cnt = dec_in_cnt + 32'd1;
            case (dec_phase)
                PH_HEADER:
                begin
                    if (dec_hdr_cnt == 4'd0)
                    begin
                        dec_out_size = '0;
                        dec_in_size  = '0;
                    end
                    if (dec_hdr_cnt >= 4'd4 && dec_hdr_cnt <= 4'd7)
                        dec_out_size[8*dec_hdr_cnt[1:0] +: 8] = b;
                    else if (dec_hdr_cnt >= 4'd8 && dec_hdr_cnt <= 4'd11)
                        dec_in_size[8*dec_hdr_cnt[1:0] +: 8] = b;
                    if (dec_hdr_cnt == 4'd15)
                    begin
                        dec_hdr_cnt    = '0;
                        dec_in_cnt     = '0;
                        dec_out_cnt    = '0;
                        dec_lit_left   = '0;
                        dec_match_left = '0;
                        dec_offset     = '0;
                        dec_phase      = PH_TOKEN;
                    end
                    else
                    begin
                        dec_hdr_cnt = dec_hdr_cnt + 4'd1;
                    end
                end
                PH_TOKEN:
                begin
                    dec_lit_left   = 24'(b[7:4]);
                    dec_match_left = 24'(b[3:0]) + 24'd4;
                    if (b[7:4] == lz4bd_pkg::LIT_EXT_CODE)
                        dec_phase = PH_LIT_EXT;
                    else if (b[7:4] != 4'd0)
                        dec_phase = PH_LITERAL;
                    else
                        close_literals();
                end
                PH_LIT_EXT:
                begin
                    dec_lit_left = grow_len(dec_lit_left, b);
                    if (b != lz4bd_pkg::EXT_BYTE)
                        dec_phase = PH_LITERAL;
                end
                PH_LITERAL:
                begin
                    put_byte(b);
                    if (dec_lit_left > 0)
                        dec_lit_left = dec_lit_left - 24'd1;
                    if (dec_lit_left == 0)
                        close_literals();
                end
                PH_OFF_LO:
                begin
                    dec_offset = {8'd0, b};
                    dec_phase  = PH_OFF_HI;
                end
                PH_OFF_HI:
                begin
                    dec_offset[15:8] = b;
                    if (dec_match_left == lz4bd_pkg::MATCH_EXT_CODE)
                        dec_phase = PH_MATCH_EXT;
                    else
                        open_match();
                end
                default:
                begin
                    dec_match_left = grow_len(dec_match_left, b);
                    if (b != lz4bd_pkg::EXT_BYTE)
                        open_match();
                end
            endcase
        end
        cur.match_pending = (dec_phase == PH_MATCH);
        cur.block_done    = (dec_phase == PH_HEADER && dec_hdr_cnt == 4'd0);
        expected_results.push_back(cur);
    endfunction

    // ---------------- stimulus building ----------------
    task automatic push_byte(logic [7:0] b);
        req_t it;
        it.cmd     = lz4bd_pkg::CMD_BYTE;
        it.in_byte = b;
        pending_items.push_back(it);
        pushed_items++;
    endtask

    task automatic push_drain(logic [7:0] junk);
        req_t it;
        it.cmd     = lz4bd_pkg::CMD_DRAIN;
        it.in_byte = junk;
        pending_items.push_back(it);
        pushed_items++;
    endtask

    task automatic push_header(logic [31:0] osz, logic [31:0] isz);
        for (int i = 0; i < 16; i++)
        begin
            if (i >= 4 && i <= 7)
                push_byte(osz[8*(i-4) +: 8]);
            else if (i >= 8 && i <= 11)
                push_byte(isz[8*(i-8) +: 8]);
            else
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // block, well-formed unless noisy: the compressed size is counted as built
    task automatic push_block(int nseq, bit noisy);
        byte unsigned payload[$];
        int drains[$];
        int outc;
        int lit;
        int mlen;
        int off;
        int ext;
        int osz;
        int k;
        int d;
        outc = 0;
        for (int s = 0; s < nseq; s++)
        begin
            bit last_seq;
            last_seq = (s == nseq - 1);
            lit = ($urandom_range(0, 29) == 0) ? int'($urandom_range(15, 300))
                                               : int'($urandom_range(0, 6));
            if (s == 0 && lit == 0)
                lit = 1;
            mlen = ($urandom_range(0, 23) == 0) ? int'($urandom_range(19, 280))
                                                : int'($urandom_range(4, 10));
            payload.push_back({(lit >= 15) ? 4'd15 : lit[3:0],
                               (mlen >= 19) ? 4'd15 : mlen[3:0] - 4'd4});
            if (lit >= 15)
            begin
                ext = lit - 15;
                while (ext >= 255)
                begin
                    payload.push_back(8'd255);
                    ext -= 255;
                end
                payload.push_back(ext[7:0]);
            end
            for (int i = 0; i < lit; i++)
                payload.push_back(8'($urandom_range(0, 255)));
            outc += lit;
            if (last_seq)
            begin
                drains.push_back(-1);
                break;
            end
            off = (outc == 0) ? 0 : int'($urandom_range(1, (outc < 40) ? outc : 40));
            if (noisy && $urandom_range(0, 5) == 0)
                off = outc + int'($urandom_range(1, 3));
            payload.push_back(off[7:0]);
            payload.push_back(off[15:8]);
            if (mlen >= 19)
            begin
                ext = mlen - 19;
                while (ext >= 255)
                begin
                    payload.push_back(8'd255);
                    ext -= 255;
                end
                payload.push_back(ext[7:0]);
            end
            if (off == 0 || off > outc)
            begin
                drains.push_back(0);
            end
            else
            begin
                drains.push_back(mlen);
                outc += mlen;
            end
            // mark where in the payload this sequence ends
            drains.push_back(payload.size() + 100000);
        end
        osz = outc;
        if (noisy && $urandom_range(0, 3) == 0)
            osz = outc - int'($urandom_range(0, 4));
        if (osz < 0)
            osz = 0;
        push_header(32'(osz), 32'(payload.size()));
        k = 0;
        for (int i = 0; i < drains.size(); i += 2)
        begin
            int endp;
            if (drains[i] < 0)
            begin
                while (k < payload.size())
                begin
                    push_byte(payload[k]);
                    k++;
                end
                break;
            end
            endp = drains[i+1] - 100000;
            while (k < endp)
            begin
                push_byte(payload[k]);
                k++;
            end
            d = drains[i];
            for (int j = 0; j < d; j++)
            begin
                if (noisy && $urandom_range(0, 30) == 0)
                    push_byte(8'($urandom_range(0, 255)));
                push_drain(8'($urandom_range(0, 255)));
            end
        end
        if (noisy && $urandom_range(0, 3) == 0)
            push_drain(8'($urandom_range(0, 255)));
    endtask

    // ---------------- driver ----------------
    int   src_gap;
    req_t cur_item;

    always @(posedge clk or negedge rst_n)
    begin
        req_t seen;
        if (!rst_n)
        begin
            compressed.valid   <= 1'b0;
            compressed.cmd     <= lz4bd_pkg::CMD_BYTE;
            compressed.in_byte <= 8'd0;
            src_gap            <= 0;
        end
        else
        begin
            if (compressed.valid && compressed.ready)
            begin
                seen.cmd     = compressed.cmd;
                seen.in_byte = compressed.in_byte;
                predict_decode(seen);
            end
            if (compressed.valid && !compressed.ready)
            begin
                // hold the offered item
            end
            else if (src_gap > 0)
            begin
                src_gap          <= src_gap - 1;
                compressed.valid <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                src_gap          <= $urandom_range(0, 12);
                compressed.valid <= 1'b0;
            end
            else if (!sender_hold && pending_items.size() > 0)
            begin
                cur_item            = pending_items.pop_front();
                compressed.valid   <= 1'b1;
                compressed.cmd     <= cur_item.cmd;
                compressed.in_byte <= cur_item.in_byte;
            end
            else
            begin
                compressed.valid <= 1'b0;
            end
        end
    end

    // ---------------- long receiver stall ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_hold_cycles <= 0;
            holds_served     <= 0;
        end
        else if (sink_hold_cycles > 0)
        begin
            sink_hold_cycles <= sink_hold_cycles - 1;
        end
        else if (holds_served != hold_requests)
        begin
            sink_hold_cycles <= HOLD_LEN;
            holds_served     <= holds_served + 1;
        end
    end

    // ---------------- monitor ----------------
    int sink_gap;

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            decompressed.ready <= 1'b0;
            sink_gap           <= 0;
            idle_cycles        <= 0;
        end
        else
        begin
            if (decompressed.valid && decompressed.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (decompressed.has_byte !== exp_r.has_byte)
                    begin
                        $error("has_byte exp %0d got %0d", exp_r.has_byte,
                               decompressed.has_byte);
                        errors++;
                    end
                    if (decompressed.out_byte !== exp_r.out_byte)
                    begin
                        $error("out_byte exp %0h got %0h", exp_r.out_byte,
                               decompressed.out_byte);
                        errors++;
                    end
                    if (decompressed.last_byte !== exp_r.last_byte)
                    begin
                        $error("last_byte exp %0d got %0d", exp_r.last_byte,
                               decompressed.last_byte);
                        errors++;
                    end
                    if (decompressed.match_pending !== exp_r.match_pending)
                    begin
                        $error("match_pending exp %0d got %0d", exp_r.match_pending,
                               decompressed.match_pending);
                        errors++;
                    end
                    if (decompressed.block_done !== exp_r.block_done)
                    begin
                        $error("block_done exp %0d got %0d", exp_r.block_done,
                               decompressed.block_done);
                        errors++;
                    end
                    if (decompressed.status !== exp_r.status)
                    begin
                        $error("status exp %0d got %0d", exp_r.status,
                               decompressed.status);
                        errors++;
                    end
                end
            end
            if ((decompressed.valid && decompressed.ready)
                    || (compressed.valid && compressed.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (sink_hold_cycles > 0)
            begin
                decompressed.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap           <= sink_gap - 1;
                decompressed.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                sink_gap           <= $urandom_range(0, 12);
                decompressed.ready <= 1'b0;
            end
            else
            begin
                decompressed.ready <= 1'b1;
            end
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() > 0 || compressed.valid
               || expected_results.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        errors         = 0;
        gen_done       = 1'b0;
        sender_hold    = 1'b0;
        quiet_tail     = 1'b0;
        hold_requests  = 0;
        pushed_items   = 0;
        dec_phase      = PH_HEADER;
        dec_hdr_cnt    = '0;
        dec_out_size   = '0;
        dec_in_size    = '0;
        dec_in_cnt     = '0;
        dec_out_cnt    = '0;
        dec_lit_left   = '0;
        dec_match_left = '0;
        dec_offset     = '0;
        for (int i = 0; i < WIN; i++)
            dec_hist[i] = 8'd0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle drain, zero offset, overrun, long literal run
        push_drain(8'hFF);
        push_header(32'd3, 32'd4);
        push_byte(8'h10);                // one literal, match 4
        push_byte(8'hFF);
        push_byte(8'h00);                // zero offset gives bad offset
        push_byte(8'h00);
        push_byte(8'h00);                // empty literal run ends the block
        push_header(32'd1, 32'd3);
        push_byte(8'h20);                // two literals into size 1: overrun
        push_byte(8'h00);
        push_byte(8'hA5);
        push_header(32'd15, 32'd17);
        push_byte(8'hF0);                // literal length through extension byte
        push_byte(8'h00);
        for (int i = 0; i < 15; i++)
            push_byte(8'($urandom_range(0, 255)));
        wait_drained();

        for (int b = 0; b < 3; b++)
            push_block($urandom_range(2, 5), 1'b0);
        wait_drained();

        // long receiver stall while sender keeps offering
        hold_requests = hold_requests + 1;
        for (int b = 0; b < 2; b++)
            push_block(4, 1'b0);
        wait_drained();

        // sender pauses mid-stream until all expected results arrived
        for (int b = 0; b < 2; b++)
            push_block(3, 1'b0);
        repeat (30) @(negedge clk);
        sender_hold = 1'b1;
        while (expected_results.size() > 0 || compressed.valid)
            @(negedge clk);
        sender_hold = 1'b0;
        wait_drained();

        while (pushed_items < 880)
        begin
            push_block($urandom_range(1, 6), $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 6) == 0)
                push_drain(8'($urandom_range(0, 255)));
            wait_drained();
        end
        quiet_tail = 1'b1;
        push_block(3, 1'b0);
        wait_drained();
        repeat (20) @(posedge clk);
        gen_done = 1'b1;
    end

    initial
    begin
        wait (gen_done || idle_cycles >= WD_LIMIT);
        if (!gen_done)
            $display("Regression FAIL");
        else if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
